// ===== hdl/asmap_pkg.sv =====
// ----------------------------------------------------------------------------
// asmap_pkg
// Shared widths, character codes and helpers for the sizes area parser.
// ----------------------------------------------------------------------------
package asmap_pkg;

	localparam int CODE_W  = 16;
	localparam int AREA_W  = 21;
	localparam int DIM_MAX_DEFAULT = 1024;

	localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

	localparam logic [CODE_W-1:0] CH_SPACE = 16'h0020;
	localparam logic [CODE_W-1:0] CH_TAB   = 16'h0009;
	localparam logic [CODE_W-1:0] CH_LF    = 16'h000A;
	localparam logic [CODE_W-1:0] CH_CR    = 16'h000D;
	localparam logic [CODE_W-1:0] CH_FF    = 16'h000C;
	localparam logic [CODE_W-1:0] CH_0     = 16'h0030;
	localparam logic [CODE_W-1:0] CH_9     = 16'h0039;
	localparam logic [CODE_W-1:0] CH_X_LO  = 16'h0078;
	localparam logic [CODE_W-1:0] CH_X_UP  = 16'h0058;
	localparam logic [CODE_W-1:0] CH_A_UP  = 16'h0041;
	localparam logic [CODE_W-1:0] CH_Z_UP  = 16'h005A;
	localparam logic [CODE_W-1:0] CASE_OFS = 16'h0020;
	localparam logic [CODE_W-1:0] CH_A_LO  = 16'h0061;
	localparam logic [CODE_W-1:0] CH_N_LO  = 16'h006E;
	localparam logic [CODE_W-1:0] CH_Y_LO  = 16'h0079;

	localparam logic [1:0] ANY_LEN = 2'd3;

	function automatic logic [CODE_W-1:0] any_char(input logic [1:0] pos);
		logic [CODE_W-1:0] r;
		case (pos)
			2'd0:    r = CH_A_LO;
			2'd1:    r = CH_N_LO;
			2'd2:    r = CH_Y_LO;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic is_space(input logic [CODE_W-1:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
			(c == CH_CR) || (c == CH_FF);
	endfunction

endpackage

// ===== hdl/artwork_sizes_max_area_parser.sv =====
// ----------------------------------------------------------------------------
// artwork_sizes_max_area_parser
// Scans a sizes string one code unit per word, keeps the largest valid
// width x height area and whether an "any" token was seen.
// ----------------------------------------------------------------------------
// result: word on m_tvalid once the last code unit has passed every stage
// throughput: one code unit per cycle; the pipe stalls only when a finished
//   result meets a still occupied, unread output register
// stages: input register, tokeniser, 11x11 (dimension) multiplier, max compare
// reset: arst_n clears token state, running maximum, any flag and all valids
module artwork_sizes_max_area_parser #(
	parameter int MAX_DIM = asmap_pkg::DIM_MAX_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // code_unit[15:0]
	input  logic        s_tlast,  // last_unit
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // max_area[20:0], any_seen[21], zero[23:22]
);
	import asmap_pkg::*;

	localparam int DW = $clog2(MAX_DIM + 2);
	localparam int AW = DW + 4;
	localparam int PW = (2 * DW > AREA_W) ? 2 * DW : AREA_W;
	localparam logic [AW-1:0] MAX_EXT = AW'(MAX_DIM);
	localparam logic [DW-1:0] MAX_DW  = DW'(MAX_DIM);
	localparam logic [DW-1:0] SAT_DW  = DW'(MAX_DIM + 1);

	typedef struct packed {
		logic          in_token;
		logic          sep;
		logic          invalid;
		logic [1:0]    prog;
		logic          mismatch;
		logic [DW-1:0] w;
		logic          wd;
		logic [DW-1:0] h;
		logic          hd;
	} tok_t;

	logic              adv;
	logic              v_s1, last_s1;
	logic [CODE_W-1:0] code_s1;
	tok_t              tok_q, tok_take, tok_sel;
	logic              v_s2, last_s2, cand_s2, any_s2;
	logic [DW-1:0]     w_s2, h_s2;
	logic              v_s3, last_s3, cand_s3, any_s3;
	logic [PW-1:0]     area_s3;
	logic [AREA_W-1:0] best_q, area_sat, best_new;
	logic              any_q, any_new;
	logic              out_valid_q, out_any_q;
	logic [AREA_W-1:0] out_area_q;
	logic              c_space, c_digit, c_sep, do_close, close_any, close_num;
	logic [CODE_W-1:0] c_low;
	logic [3:0]        digit;
	logic [AW-1:0]     acc_in, acc_next;
	logic [DW-1:0]     acc_sat;

	assign adv      = !(v_s3 && last_s3 && out_valid_q && !m_tready);
	assign s_tready = adv;

	// tokeniser
	assign c_space = is_space(code_s1);
	assign c_digit = (code_s1 >= CH_0) && (code_s1 <= CH_9);
	assign c_sep   = (code_s1 == CH_X_LO) || (code_s1 == CH_X_UP);
	assign c_low   = ((code_s1 >= CH_A_UP) && (code_s1 <= CH_Z_UP)) ?
		code_s1 + CASE_OFS : code_s1;
	assign digit   = code_s1[3:0];

	always_comb begin
		acc_in   = tok_q.sep ? AW'(tok_q.h) : AW'(tok_q.w);
		acc_next = (acc_in << 3) + (acc_in << 1) + AW'(digit);
		acc_sat  = (acc_next > MAX_EXT) ? SAT_DW : acc_next[DW-1:0];
	end

	always_comb begin
		tok_take = tok_q;
		tok_take.in_token = 1'b1;
		if (!tok_q.mismatch) begin
			if ((tok_q.prog != ANY_LEN) && (c_low == any_char(tok_q.prog))) begin
				tok_take.prog = tok_q.prog + 2'd1;
			end else begin
				tok_take.mismatch = 1'b1;
			end
		end
		if (c_sep) begin
			if (tok_q.sep) begin
				tok_take.invalid = 1'b1;
			end else begin
				tok_take.sep = 1'b1;
			end
		end else if (c_digit) begin
			if (tok_q.sep) begin
				tok_take.h  = acc_sat;
				tok_take.hd = 1'b1;
			end else begin
				tok_take.w  = acc_sat;
				tok_take.wd = 1'b1;
			end
		end else begin
			tok_take.invalid = 1'b1;
		end
	end

	always_comb begin
		tok_sel   = c_space ? tok_q : tok_take;
		do_close  = c_space || last_s1;
		close_any = tok_sel.in_token && !tok_sel.mismatch && (tok_sel.prog == ANY_LEN);
		close_num = tok_sel.in_token && !close_any && !tok_sel.invalid && tok_sel.sep &&
			tok_sel.wd && tok_sel.hd &&
			(tok_sel.w != '0) && (tok_sel.w <= MAX_DW) &&
			(tok_sel.h != '0) && (tok_sel.h <= MAX_DW);
	end

	// running maximum
	always_comb begin
		area_sat = (area_s3 > PW'(AREA_MAX)) ? AREA_MAX : area_s3[AREA_W-1:0];
		best_new = (cand_s3 && (area_sat > best_q)) ? area_sat : best_q;
		any_new  = any_q | any_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			cand_s2     <= 1'b0;
			any_s2      <= 1'b0;
			cand_s3     <= 1'b0;
			any_s3      <= 1'b0;
			tok_q       <= '0;
			best_q      <= '0;
			any_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv && v_s3 && last_s3) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (adv) begin
				v_s1    <= s_tvalid;
				v_s2    <= v_s1;
				cand_s2 <= v_s1 && do_close && close_num;
				any_s2  <= v_s1 && do_close && close_any;
				v_s3    <= v_s2;
				cand_s3 <= cand_s2;
				any_s3  <= any_s2;
				if (v_s1) begin
					tok_q <= do_close ? '0 : tok_take;
				end
				if (v_s3) begin
					if (last_s3) begin
						best_q <= '0;
						any_q  <= 1'b0;
					end else begin
						best_q <= best_new;
						any_q  <= any_new;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			code_s1 <= s_tdata;
			last_s1 <= s_tlast;
			w_s2    <= tok_sel.w;
			h_s2    <= tok_sel.h;
			last_s2 <= last_s1;
			area_s3 <= PW'(w_s2) * PW'(h_s2);
			last_s3 <= last_s2;
			if (v_s3 && last_s3) begin
				out_area_q <= best_new;
				out_any_q  <= any_new;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_any_q, out_area_q};

	// checks
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (out_valid_q && !m_tready))
		else $error("input stalled without a blocked result");

	a_best_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s3 && last_s3) |=> ((best_q == '0) && !any_q && out_valid_q))
		else $error("running maximum not cleared after a result");

	a_token_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s1 && last_s1) |=> !tok_q.in_token)
		else $error("token state left open after last code unit");

	a_cand_dims: assert property (@(posedge clk) disable iff (!arst_n)
		cand_s2 |-> ((w_s2 != '0) && (w_s2 <= MAX_DW) && (h_s2 != '0) && (h_s2 <= MAX_DW)))
		else $error("candidate dimension out of range");

endmodule
